// ----- design/tcit_pkg.sv -----
// Shared types and constants for the three-channel interval timer.
`default_nettype none

package tcit_pkg;

  localparam int unsigned TCIT_NUM_CH = 3;
  localparam int unsigned TCIT_CH_W   = $clog2(TCIT_NUM_CH);
  localparam int unsigned TCIT_DIV_W  = 5;

  localparam logic [31:0] TCIT_DEFAULT_RELOAD = 32'd1000;
  localparam logic [31:0] TCIT_BYTE_MASK      = 32'h0000_00FF;

  // Item operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_SERVICE = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 load;        // capture the input beat
    logic                 exec;        // run the bus/service action, fill output register
    logic                 sub;         // count -= elapsed on the current channel
    logic                 div_start;   // begin overshoot remainder
    logic                 div_step;    // one restoring-division step
    logic                 div_finish;  // reload from remainder
    logic [TCIT_CH_W-1:0] ch;          // channel under work
  } tcit_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_tick;       // incoming beat is a tick
    logic chan_enabled;  // current channel has a nonzero reload
    logic chan_wrap;     // elapsed reaches or passes the current count
    logic div_last;      // this is the final division step
    logic out_free;      // output register can take a result this cycle
  } tcit_status_t;

endpackage

`default_nettype wire

// ----- design/tcit_ctrl.sv -----
// Controller state machine: sequences bus items and per-channel tick work.
`default_nettype none

module tcit_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcit_pkg::tcit_status_t status,
  output tcit_pkg::tcit_cmd_t    cmd
);
  import tcit_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHAN   = 5'b00010,
    S_DIV    = 5'b00100,
    S_FIN    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [TCIT_CH_W-1:0] ch, ch_next;
  logic                 last_ch;

  assign last_ch = (ch == TCIT_CH_W'(TCIT_NUM_CH - 1));

  // Next-state and command decode
  always_comb begin
    state_next     = state;
    ch_next        = ch;
    cmd            = '0;
    cmd.ch         = ch;
    in_stall       = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.load   = 1'b1;
          ch_next    = '0;
          state_next = status.in_tick ? S_CHAN : S_RESULT;
        end
      end
      S_CHAN: begin
        if (status.chan_enabled && status.chan_wrap) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.sub = status.chan_enabled;
          if (last_ch) begin
            state_next = S_RESULT;
          end else begin
            ch_next = ch + 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        if (last_ch) begin
          state_next = S_RESULT;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = S_CHAN;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcit_datapath.sv -----
// Datapath: channel registers, shared remainder divider and output register.
`default_nettype none

module tcit_datapath #(
  parameter logic [31:0] CHANNEL_BASE_ADDR = 32'd64,
  parameter logic [31:0] STATUS_ADDR       = 32'd67,
  parameter logic [31:0] COMMAND_ADDR      = 32'd68,
  parameter logic [7:0]  VECTOR_NUMBER     = 8'd32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             operation,
  input  logic                   access_size,
  input  logic [31:0]            address,
  input  logic [31:0]            write_data,
  input  logic [31:0]            tick_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            read_data,
  output logic                   irq_taken,
  output logic [7:0]             irq_vector_out,
  input  tcit_pkg::tcit_cmd_t    cmd,
  output tcit_pkg::tcit_status_t status
);
  import tcit_pkg::*;

  // Captured item
  logic [1:0]  op_q;
  logic        size_q;
  logic [31:0] addr_q;
  logic [31:0] wdata_q;
  logic [31:0] elapsed_q;

  // Timer state
  logic [31:0] reload_q [TCIT_NUM_CH];
  logic [31:0] count_q  [TCIT_NUM_CH];
  logic        pending;

  // Divider
  logic [31:0]           rem;
  logic [31:0]           dvd;
  logic [TCIT_DIV_W-1:0] div_cnt;

  logic [31:0]          cur_reload;
  logic [31:0]          cur_count;
  logic [32:0]          trial;
  logic [32:0]          trial_diff;
  logic                 trial_ge;
  logic [31:0]          chan_off;
  logic                 chan_hit;
  logic [TCIT_CH_W-1:0] chan_sel;
  logic [31:0]          wval_raw;
  logic [31:0]          wval;
  logic                 is_status;
  logic                 is_command;
  logic [31:0]          rd_val;

  assign cur_reload = reload_q[cmd.ch];
  assign cur_count  = count_q[cmd.ch];

  // Restoring division step on the overshoot
  assign trial      = {rem, dvd[31]};
  assign trial_diff = trial - {1'b0, cur_reload};
  assign trial_ge   = (trial >= {1'b0, cur_reload});

  // Bus decode
  assign chan_off   = addr_q - CHANNEL_BASE_ADDR;
  assign chan_hit   = (chan_off < 32'(TCIT_NUM_CH));
  assign chan_sel   = chan_off[TCIT_CH_W-1:0];
  assign is_status  = (addr_q == STATUS_ADDR);
  assign is_command = (addr_q == COMMAND_ADDR);
  assign wval_raw   = size_q ? wdata_q : (wdata_q & TCIT_BYTE_MASK);
  assign wval       = (wval_raw == '0) ? 32'd1 : wval_raw;

  // Read value, status taking precedence over channels
  always_comb begin
    rd_val = '0;
    if (is_status) begin
      rd_val = {31'd0, pending};
    end else if (chan_hit) begin
      rd_val = size_q ? count_q[chan_sel] : (count_q[chan_sel] & TCIT_BYTE_MASK);
    end
  end

  assign status.in_tick      = (operation == OP_TICK);
  assign status.chan_enabled = (cur_reload != '0);
  assign status.chan_wrap    = (elapsed_q >= cur_count);
  assign status.div_last     = (div_cnt == '1);
  assign status.out_free     = !out_valid || !out_stall;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      size_q    <= access_size;
      addr_q    <= address;
      wdata_q   <= write_data;
      elapsed_q <= tick_ms;
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      dvd     <= elapsed_q - cur_count;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? trial_diff[31:0] : trial[31:0];
      dvd     <= {dvd[30:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Channel registers and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TCIT_NUM_CH; i++) begin
        reload_q[i] <= (i == 0) ? TCIT_DEFAULT_RELOAD : '0;
        count_q[i]  <= (i == 0) ? TCIT_DEFAULT_RELOAD : '0;
      end
      pending <= 1'b0;
    end else begin
      if (cmd.sub) begin
        count_q[cmd.ch] <= cur_count - elapsed_q;
      end
      if (cmd.div_finish) begin
        count_q[cmd.ch] <= cur_reload - rem;
        if (cmd.ch == '0) begin
          pending <= 1'b1;
        end
      end
      if (cmd.exec) begin
        case (op_q)
          OP_WRITE: begin
            if (!is_command) begin
              if (is_status) begin
                pending <= 1'b0;
              end else if (chan_hit) begin
                reload_q[chan_sel] <= wval;
                count_q[chan_sel]  <= wval;
              end
            end
          end
          OP_SERVICE: begin
            pending <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data      <= (op_q == OP_READ) ? rd_val : '0;
      irq_taken      <= (op_q == OP_SERVICE) && pending;
      irq_vector_out <= ((op_q == OP_SERVICE) && pending) ? VECTOR_NUMBER : '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/three_channel_interval_timer.sv -----
// Top level of the three-channel interval timer.
// Three reload-down counters behind a bus register map; every input beat
// (tick, bus read, bus write, interrupt service) yields exactly one output
// beat. One item is in work at a time. A bus or service item is captured,
// then written to the output register once that register is free. A tick
// walks the channels in turn: a disabled channel is skipped and one that does
// not reach zero is counted down, while for a channel that reaches or passes
// zero the overshoot remainder runs through one shared restoring divider at
// one quotient bit per cycle before the channel reloads. A new beat is taken as
// soon as the previous result has left or is leaving the output register.
`default_nettype none

module three_channel_interval_timer #(
  parameter logic [31:0] CHANNEL_BASE_ADDR = 32'd64,
  parameter logic [31:0] STATUS_ADDR       = 32'd67,
  parameter logic [31:0] COMMAND_ADDR      = 32'd68,
  parameter logic [7:0]  VECTOR_NUMBER     = 8'd32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic        access_size,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] tick_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_taken,
  output logic [7:0]  irq_vector_out
);
  import tcit_pkg::*;

  tcit_cmd_t    cmd;
  tcit_status_t status;

  tcit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tcit_datapath #(
    .CHANNEL_BASE_ADDR (CHANNEL_BASE_ADDR),
    .STATUS_ADDR       (STATUS_ADDR),
    .COMMAND_ADDR      (COMMAND_ADDR),
    .VECTOR_NUMBER     (VECTOR_NUMBER)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .access_size    (access_size),
    .address        (address),
    .write_data     (write_data),
    .tick_ms        (tick_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .irq_taken      (irq_taken),
    .irq_vector_out (irq_vector_out),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire

// ----- design/tcit_checker.sv -----
// Port-level checks for the interval timer, bound to the top level.
`default_nettype none

module tcit_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] read_data,
  input logic        irq_taken,
  input logic [7:0]  irq_vector_out
);

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq_taken)
      && $stable(irq_vector_out))
    else $error("output beat changed while stalled");

  // One item at a time: the cycle after an accepted beat the input is stalled
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in work");

  // A vector only accompanies a taken interrupt
  a_vec_with_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !irq_taken |-> irq_vector_out == 8'd0)
    else $error("vector without taken interrupt");

  // A result with a taken interrupt never carries read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_taken |-> read_data == 32'd0)
    else $error("read data on a service result");

endmodule

bind three_channel_interval_timer tcit_checker u_tcit_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_data      (read_data),
  .irq_taken      (irq_taken),
  .irq_vector_out (irq_vector_out)
);

`default_nettype wire

// ----- tb/tb_three_channel_interval_timer.sv -----
// Self-checking testbench for the three-channel interval timer: directed table, then random beats.
module tb_three_channel_interval_timer;
  import tcit_pkg::*;

  localparam logic [31:0] CH_BASE    = 32'd64;
  localparam logic [31:0] STATUS_A   = 32'd67;
  localparam logic [31:0] COMMAND_A  = 32'd68;
  localparam logic [7:0]  VECTOR_NUM = 8'd32;

  localparam logic SZ_BYTE  = 1'b0;
  localparam logic SZ_DWORD = 1'b1;

  localparam int RANDOM_BEATS = 1925;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
    logic [7:0]  vec;
  } reply_t;

  typedef struct {
    logic [1:0]  op;
    logic        sz;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] ms;
    bit          chk;   // reply typed into the table
    reply_t      want;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic        access_size;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] tick_ms;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        irq_taken;
  logic [7:0]  irq_vector_out;

  // Predicted timer state
  logic [31:0] reload_q [TCIT_NUM_CH];
  logic [31:0] count_q  [TCIT_NUM_CH];
  logic        pend_flag;

  reply_t      replies_due [$];
  beat_t       directed_rows [$];
  beat_t       drv_beat;
  int unsigned beats_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_stall_pct = 51;

  three_channel_interval_timer #(
    .CHANNEL_BASE_ADDR(CH_BASE),
    .STATUS_ADDR      (STATUS_A),
    .COMMAND_ADDR     (COMMAND_A),
    .VECTOR_NUMBER    (VECTOR_NUM)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .access_size   (access_size),
    .address       (address),
    .write_data    (write_data),
    .tick_ms       (tick_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .irq_taken     (irq_taken),
    .irq_vector_out(irq_vector_out)
  );

  always #5 clk = ~clk;

  // Applies one beat to the predicted state and returns the reply it should produce
  function automatic reply_t next_timer_reply(input logic [1:0] op, input logic dword,
      input logic [31:0] addr, input logic [31:0] data, input logic [31:0] ms);
    reply_t      r;
    logic [31:0] ch;
    logic [31:0] v;
    r  = '0;
    ch = addr - CH_BASE;
    case (op)
      OP_TICK: begin
        for (int c = 0; c < TCIT_NUM_CH; c++) begin
          // zero reload means the channel is off
          if (reload_q[c] != 32'd0) begin
            if (ms >= count_q[c]) begin
              count_q[c] = reload_q[c] - (ms - count_q[c]) % reload_q[c];
              if (c == 0) pend_flag = 1'b1;
            end else begin
              count_q[c] = count_q[c] - ms;
            end
          end
        end
      end
      OP_READ: begin
        // status wins over channels
        if (addr == STATUS_A) r.rd = {31'd0, pend_flag};
        else if (ch < TCIT_NUM_CH) r.rd = dword ? count_q[ch] : count_q[ch] & TCIT_BYTE_MASK;
      end
      OP_WRITE: begin
        // command write is swallowed; status write clears the flag
        if (addr != COMMAND_A) begin
          if (addr == STATUS_A) begin
            pend_flag = 1'b0;
          end else if (ch < TCIT_NUM_CH) begin
            v = dword ? data : data & TCIT_BYTE_MASK;
            if (v == 32'd0) v = 32'd1;
            reload_q[ch] = v;
            count_q[ch]  = v;
          end
        end
      end
      OP_SERVICE: begin
        if (pend_flag) begin
          pend_flag = 1'b0;
          r.irq     = 1'b1;
          r.vec     = VECTOR_NUM;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Check result beats, then log accepted input beats
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no reply expected");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (read_data !== want.rd) begin
            $error("read_data: expected %h, got %h", want.rd, read_data);
            mismatches++;
          end
          if (irq_taken !== want.irq) begin
            $error("irq_taken: expected %b, got %b", want.irq, irq_taken);
            mismatches++;
          end
          if (irq_vector_out !== want.vec) begin
            $error("irq_vector_out: expected %h, got %h", want.vec, irq_vector_out);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = next_timer_reply(operation, access_size, address, write_data, tick_ms);
        if (drv_beat.chk) want = drv_beat.want;
        replies_due.push_back(want);
        beats_taken++;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) out_stall = ($urandom_range(99) < recv_stall_pct);

  task automatic add_row(input logic [1:0] op, input logic sz, input logic [31:0] addr,
      input logic [31:0] data, input logic [31:0] ms, input bit chk,
      input logic [31:0] rd, input logic irq, input logic [7:0] vec);
    beat_t b;
    b.op   = op;
    b.sz   = sz;
    b.addr = addr;
    b.data = data;
    b.ms   = ms;
    b.chk  = chk;
    b.want = '{rd: rd, irq: irq, vec: vec};
    directed_rows.push_back(b);
  endtask

  // Present one beat at the falling edge and hold it until it is taken
  task automatic drive_beat(input beat_t b);
    int unsigned seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    drv_beat    = b;
    operation   = b.op;
    access_size = b.sz;
    address     = b.addr;
    write_data  = b.data;
    tick_ms     = b.ms;
    in_valid    = 1'b1;
    seen        = beats_taken;
    do @(negedge clk); while (beats_taken == seen);
  endtask

  initial begin
    beat_t       b;
    int unsigned roll;
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_TICK;
    access_size = SZ_BYTE;
    address     = '0;
    write_data  = '0;
    tick_ms     = '0;
    drv_beat    = '{op: OP_TICK, sz: SZ_BYTE, addr: '0, data: '0, ms: '0, chk: 1'b0, want: '0};
    foreach (reload_q[c]) begin
      reload_q[c] = '0;
      count_q[c]  = '0;
    end
    reload_q[0] = TCIT_DEFAULT_RELOAD;
    count_q[0]  = TCIT_DEFAULT_RELOAD;
    pend_flag   = 1'b0;

    // Directed table: values after reset, wrap on exact zero, service with and
    // without flag, zero and byte-masked divisors, full-range tick, status clear,
    // command and unmapped accesses
    add_row(OP_READ,    SZ_DWORD, CH_BASE,        '0,           '0,           1, 32'd1000, 0, 0);
    add_row(OP_READ,    SZ_BYTE,  CH_BASE,        32'hFFFF_FFFF,'0,           1, 32'hE8,   0, 0);
    add_row(OP_READ,    SZ_DWORD, STATUS_A,       '0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_BYTE,  COMMAND_A,      '0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_SERVICE, SZ_BYTE,  '0,             '0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_TICK,    SZ_DWORD, CH_BASE,        32'hFFFF_FFFF,32'd999,      1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, CH_BASE,        '0,           32'hFFFF_FFFF,1, 32'd1,    0, 0);
    add_row(OP_TICK,    SZ_BYTE,  '0,             '0,           32'd1,        1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_BYTE,  STATUS_A,       '0,           '0,           1, 32'd1,    0, 0);
    add_row(OP_SERVICE, SZ_DWORD, 32'hFFFF_FFFF,  32'hFFFF_FFFF,32'hFFFF_FFFF,1, 32'd0, 1, VECTOR_NUM);
    add_row(OP_SERVICE, SZ_BYTE,  '0,             '0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_WRITE,   SZ_DWORD, CH_BASE + 32'd1,'0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, CH_BASE + 32'd1,'0,           '0,           1, 32'd1,    0, 0);
    add_row(OP_WRITE,   SZ_BYTE,  CH_BASE + 32'd2,32'hFFFF_FF00,'0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, CH_BASE + 32'd2,'0,           '0,           1, 32'd1,    0, 0);
    add_row(OP_WRITE,   SZ_BYTE,  CH_BASE + 32'd2,32'hFFFF_FFFF,'0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, CH_BASE + 32'd2,'0,           '0,           1, 32'd255,  0, 0);
    add_row(OP_WRITE,   SZ_DWORD, CH_BASE,        32'hFFFF_FFFF,'0,           1, 32'd0,    0, 0);
    add_row(OP_TICK,    SZ_BYTE,  '0,             '0,           32'hFFFF_FFFF,0, '0,       0, 0);
    add_row(OP_READ,    SZ_DWORD, CH_BASE,        '0,           '0,           0, '0,       0, 0);
    add_row(OP_READ,    SZ_BYTE,  CH_BASE + 32'd2,'0,           '0,           0, '0,       0, 0);
    add_row(OP_TICK,    SZ_DWORD, '0,             '0,           32'd0,        0, '0,       0, 0);
    add_row(OP_WRITE,   SZ_DWORD, STATUS_A,       32'hA5A5_5A5A,'0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, STATUS_A,       '0,           '0,           1, 32'd0,    0, 0);
    add_row(OP_WRITE,   SZ_DWORD, COMMAND_A,      32'd5,        '0,           1, 32'd0,    0, 0);
    add_row(OP_WRITE,   SZ_DWORD, 32'hFFFF_FFFF,  32'd7,        '0,           1, 32'd0,    0, 0);
    add_row(OP_READ,    SZ_DWORD, 32'd0,          '0,           '0,           1, 32'd0,    0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) drive_beat(directed_rows[i]);

    // Random beats, mostly aimed at the register window with small divisors
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) begin
        send_idle_pct  = 51;
        recv_stall_pct = 31;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 30)      b.op = OP_TICK;
      else if (roll < 60) b.op = OP_READ;
      else if (roll < 85) b.op = OP_WRITE;
      else                b.op = OP_SERVICE;
      b.sz = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 88) b.addr = CH_BASE - 32'd2 + $urandom_range(8);
      else           b.addr = $urandom();
      roll = $urandom_range(99);
      if (roll < 40)      b.data = $urandom_range(40);
      else if (roll < 55) b.data = ($urandom() & ~TCIT_BYTE_MASK) | $urandom_range(40);
      else if (roll < 62) b.data = '0;
      else                b.data = $urandom();
      roll = $urandom_range(99);
      if (roll < 45)      b.ms = $urandom_range(60);
      else if (roll < 70) b.ms = $urandom_range(2000);
      else if (roll < 88) b.ms = count_q[0] - 32'd1 + $urandom_range(2);
      else                b.ms = $urandom();
      b.chk  = 1'b0;
      b.want = '0;
      drive_beat(b);
    end
    in_valid = 1'b0;

    while (replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
